FILE: rtl/core/utf8d_pkg.sv
// utf8d_pkg: widths, constants and item types of the utf-8 stream decoder
// no dependencies; imported by every module of the decoder
`timescale 1ns / 1ps

package utf8d_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int PEND_W = 2;

    localparam logic [CP_W-1:0]   REPLACEMENT_CP = 21'h00FFFD;
    localparam logic [PEND_W-1:0] PEND_NONE      = 2'd0;
    localparam logic [PEND_W-1:0] PEND_ONE       = 2'd1;
    localparam logic [PEND_W-1:0] PEND_TWO       = 2'd2;
    localparam logic [PEND_W-1:0] PEND_THREE     = 2'd3;

    // tag bits at the top of a utf-8 byte
    localparam logic [1:0] CONT_TAG  = 2'b10;
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              final_byte;
    } utf8d_byte_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            replaced;
        logic            text_end;
    } utf8d_result_t;

endpackage

FILE: rtl/core/utf8d_in_reg.sv
// utf8d_in_reg: input register stage holding one byte item
// depends on utf8d_pkg
`timescale 1ns / 1ps

module utf8d_in_reg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  utf8d_pkg::utf8d_byte_t in_item,
    input  logic                  advance,
    output logic                  held_valid,
    output utf8d_pkg::utf8d_byte_t held_item
);
    import utf8d_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    utf8d_byte_t item_reg;

    // stage frees up whenever its item moves on in the same cycle
    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

FILE: rtl/core/utf8d_step.sv
// utf8d_step: sequence state and the per-byte decode step
// depends on utf8d_pkg
`timescale 1ns / 1ps

module utf8d_step (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    fire,
    input  utf8d_pkg::utf8d_byte_t  item,
    output logic                    has_result,
    output utf8d_pkg::utf8d_result_t result
);
    import utf8d_pkg::*;

    logic [CP_W-1:0]   partial_value_reg;
    logic [CP_W-1:0]   partial_value_next;
    logic [PEND_W-1:0] bytes_pending_reg;
    logic [PEND_W-1:0] bytes_pending_next;

    logic [BYTE_W-1:0] c;
    logic              fin;
    logic [CP_W-1:0]   lead_value;
    logic [PEND_W-1:0] lead_extra;
    logic [CP_W-1:0]   acc_value;
    logic [PEND_W-1:0] pend_dec;

    assign c   = item.text_byte;
    assign fin = item.final_byte;

    always_comb
    begin
        case (c) inside
            8'b110?????:
            begin
                lead_value = {16'd0, c[4:0]};
                lead_extra = PEND_ONE;
            end
            8'b1110????:
            begin
                lead_value = {17'd0, c[3:0]};
                lead_extra = PEND_TWO;
            end
            8'b11110???:
            begin
                lead_value = {18'd0, c[2:0]};
                lead_extra = PEND_THREE;
            end
            // ascii and invalid leads pass through as their own value
            default:
            begin
                lead_value = {13'd0, c};
                lead_extra = PEND_NONE;
            end
        endcase
    end

    assign acc_value = {partial_value_reg[CP_W-7:0], c[5:0]};
    assign pend_dec  = bytes_pending_reg - PEND_ONE;

    always_comb
    begin
        has_result         = 1'b0;
        result.code_point  = lead_value;
        result.replaced    = 1'b0;
        result.text_end    = fin;
        partial_value_next = partial_value_reg;
        bytes_pending_next = bytes_pending_reg;
        if (bytes_pending_reg == PEND_NONE)
        begin
            if (lead_extra == PEND_NONE)
            begin
                has_result = 1'b1;
            end
            else if (fin)
            begin
                has_result         = 1'b1;
                result.code_point  = REPLACEMENT_CP;
                result.replaced    = 1'b1;
                partial_value_next = '0;
                bytes_pending_next = PEND_NONE;
            end
            else
            begin
                partial_value_next = lead_value;
                bytes_pending_next = lead_extra;
            end
        end
        else
        begin
            // continuation top bits are not checked
            if (pend_dec == PEND_NONE)
            begin
                has_result         = 1'b1;
                result.code_point  = acc_value;
                partial_value_next = '0;
                bytes_pending_next = PEND_NONE;
            end
            else if (fin)
            begin
                has_result         = 1'b1;
                result.code_point  = REPLACEMENT_CP;
                result.replaced    = 1'b1;
                partial_value_next = '0;
                bytes_pending_next = PEND_NONE;
            end
            else
            begin
                partial_value_next = acc_value;
                bytes_pending_next = pend_dec;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_value_reg <= '0;
            bytes_pending_reg <= PEND_NONE;
        end
        else if (fire)
        begin
            partial_value_reg <= partial_value_next;
            bytes_pending_reg <= bytes_pending_next;
        end
    end

endmodule

FILE: rtl/core/utf8d_out_reg.sv
// utf8d_out_reg: result register in front of the output channel
// depends on utf8d_pkg
`timescale 1ns / 1ps

module utf8d_out_reg (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  utf8d_pkg::utf8d_result_t load_item,
    output logic                     slot_free,
    output logic                     out_valid,
    input  logic                     out_ready,
    output utf8d_pkg::utf8d_result_t out_item
);
    import utf8d_pkg::*;

    logic          valid_reg;
    logic          valid_next;
    utf8d_result_t item_reg;

    // a waiting result that is taken this cycle frees the slot at once
    assign slot_free  = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= load_item;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

FILE: rtl/core/utf8_stream_decoder.sv
// utf8_stream_decoder: lenient streaming utf-8 to code point decoder
// a result comes from the input register through the step into the result register
// throughput: one byte item per cycle while the result slot is free, set by the
// single decode step between the input register and the result register
// reset: rst_n clears both stage valids and the sequence state at once
// depends on utf8d_pkg, utf8d_in_reg, utf8d_step, utf8d_out_reg
`timescale 1ns / 1ps

module utf8_stream_decoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [utf8d_pkg::BYTE_W-1:0]  text_byte,
    input  logic                          final_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [utf8d_pkg::CP_W-1:0]    code_point,
    output logic                          replaced,
    output logic                          text_end
);
    import utf8d_pkg::*;

    utf8d_byte_t   in_item;
    utf8d_byte_t   held_item;
    utf8d_result_t step_result;
    utf8d_result_t out_item;
    logic          held_valid;
    logic          slot_free;
    logic          advance;
    logic          has_result;

    assign in_item.text_byte  = text_byte;
    assign in_item.final_byte = final_byte;

    // an item moves on only when the result slot can take what it may produce
    assign advance = held_valid && slot_free;

    utf8d_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    utf8d_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (advance),
        .item       (held_item),
        .has_result (has_result),
        .result     (step_result)
    );

    utf8d_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && has_result),
        .load_item (step_result),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    assign code_point = out_item.code_point;
    assign replaced   = out_item.replaced;
    assign text_end   = out_item.text_end;

endmodule

FILE: tb/utf8_decode_checker.sv
// utf8_decode_checker: watches both channels of utf8_stream_decoder, predicts code points
// from the accepted byte items and compares each accepted result field by field
// depends on utf8d_pkg
`timescale 1ns / 1ps

module utf8_decode_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [utf8d_pkg::BYTE_W-1:0]  text_byte,
    input  logic                          final_byte,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [utf8d_pkg::CP_W-1:0]    code_point,
    input  logic                          replaced,
    input  logic                          text_end,
    output int                            mismatches,
    output int                            waiting,
    output int                            checked,
    output int                            replacements
);

    import utf8d_pkg::*;

    localparam int EXP_DEPTH = 2048;

    logic [CP_W-1:0]   acc_cp   = '0;
    logic [PEND_W-1:0] acc_left = PEND_NONE;
    utf8d_result_t     exp_mem [0:EXP_DEPTH-1];
    int                exp_wr   = 0;
    int                exp_rd   = 0;

    initial
    begin
        mismatches   = 0;
        waiting      = 0;
        checked      = 0;
        replacements = 0;
    end

    task automatic queue_code_point(input logic [CP_W-1:0] cp, input logic repl,
                                    input logic last);
        utf8d_result_t r;
        r.code_point = cp;
        r.replaced   = repl;
        r.text_end   = last;
        exp_mem[exp_wr % EXP_DEPTH] = r;
        exp_wr++;
    endtask

    task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic fin);
        logic [CP_W-1:0]   lead_bits;
        logic [PEND_W-1:0] need;
        if (acc_left == PEND_NONE)
        begin
            if (!b[7])
            begin
                lead_bits = {13'd0, b};
                need      = PEND_NONE;
            end
            else if (b[7:5] == LEAD2_TAG)
            begin
                lead_bits = {16'd0, b[4:0]};
                need      = PEND_ONE;
            end
            else if (b[7:4] == LEAD3_TAG)
            begin
                lead_bits = {17'd0, b[3:0]};
                need      = PEND_TWO;
            end
            else if (b[7:3] == LEAD4_TAG)
            begin
                lead_bits = {18'd0, b[2:0]};
                need      = PEND_THREE;
            end
            else
            begin
                // stray continuation or 11111xxx passes through as its own value
                lead_bits = {13'd0, b};
                need      = PEND_NONE;
            end
            if (need == PEND_NONE)
                queue_code_point(lead_bits, 1'b0, fin);
            else if (fin)
                queue_code_point(REPLACEMENT_CP, 1'b1, 1'b1);
            else
            begin
                acc_cp   = lead_bits;
                acc_left = need;
            end
        end
        else
        begin
            // top two bits are ignored, any byte counts as a continuation
            acc_cp   = {acc_cp[CP_W-7:0], b[5:0]};
            acc_left = acc_left - PEND_ONE;
            if (acc_left == PEND_NONE)
            begin
                queue_code_point(acc_cp, 1'b0, fin);
                acc_cp = '0;
            end
            else if (fin)
            begin
                queue_code_point(REPLACEMENT_CP, 1'b1, 1'b1);
                acc_cp   = '0;
                acc_left = PEND_NONE;
            end
        end
    endtask

    always @(posedge clk)
    begin
        utf8d_result_t exp_r;
        if (!rst_n)
        begin
            acc_cp   = '0;
            acc_left = PEND_NONE;
        end
        else
        begin
            if (in_valid && in_ready)
                decode_byte(text_byte, final_byte);
            if (out_valid && out_ready)
            begin
                if (exp_wr == exp_rd)
                begin
                    mismatches++;
                    $display("%0t: unexpected item: code_point %h replaced %b text_end %b",
                             $time, code_point, replaced, text_end);
                end
                else
                begin
                    exp_r = exp_mem[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    checked++;
                    if (exp_r.replaced)
                        replacements++;
                    if (code_point !== exp_r.code_point)
                    begin
                        mismatches++;
                        $display("%0t: code_point expected %h got %h",
                                 $time, exp_r.code_point, code_point);
                    end
                    if (replaced !== exp_r.replaced)
                    begin
                        mismatches++;
                        $display("%0t: replaced expected %b got %b",
                                 $time, exp_r.replaced, replaced);
                    end
                    if (text_end !== exp_r.text_end)
                    begin
                        mismatches++;
                        $display("%0t: text_end expected %b got %b",
                                 $time, exp_r.text_end, text_end);
                    end
                end
            end
        end
        waiting = exp_wr - exp_rd;
    end

endmodule

FILE: tb/tb.sv
// tb: drives utf8_stream_decoder with directed and random byte texts, random gaps on
// both channels and one long output stall; gives the verdict from the checker's counts
// depends on utf8d_pkg, utf8_stream_decoder, utf8_decode_checker
`timescale 1ns / 1ps

module tb;

    import utf8d_pkg::*;

    localparam int TOTAL_ITEMS = 1040;
    localparam int CALM_ITEMS  = 180;
    localparam int HOLD_AT     = 550;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int TEXT_MAX    = 48;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [BYTE_W-1:0] text_byte;
    logic              final_byte;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [CP_W-1:0]   code_point;
    logic              replaced;
    logic              text_end;

    int mismatches;
    int waiting;
    int checked;
    int replacements;
    int sent;
    bit calm;
    bit hold_req;
    bit hold_done;

    // {final_byte, text_byte}
    logic [8:0] directed_bytes [0:24] = '{
        9'h000, 9'h07F,                         // ascii extremes
        9'h080, 9'h0BF, 9'h0F8, 9'h0FF,         // invalid leads pass through
        9'h0C2, 9'h0A9,                         // two-byte
        9'h0E2, 9'h082, 9'h0AC,                 // three-byte
        9'h0F0, 9'h09F, 9'h098, 9'h080,         // four-byte
        9'h0F7, 9'h0FF, 9'h0FF, 9'h0FF,         // largest code point
        9'h1E2,                                 // lead byte at end of text
        9'h0F0, 9'h19F,                         // text ends mid sequence
        9'h0C3, 9'h0E9,                         // lead where continuation belongs
        9'h141                                  // final flag on plain ascii
    };

    utf8_stream_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .text_byte  (text_byte),
        .final_byte (final_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code_point (code_point),
        .replaced   (replaced),
        .text_end   (text_end)
    );

    utf8_decode_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .text_byte    (text_byte),
        .final_byte   (final_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .code_point   (code_point),
        .replaced     (replaced),
        .text_end     (text_end),
        .mismatches   (mismatches),
        .waiting      (waiting),
        .checked      (checked),
        .replacements (replacements)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // mostly short gaps, a few long ones, none while calm
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99, 0);
        if (calm || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(3, 1);
        if (roll < 98)
            return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        text_byte  <= b;
        final_byte <= fin;
        do
            @(posedge clk);
        while (!in_ready);
        sent++;
        if (sent == HOLD_AT)
            hold_req = 1'b1;
    endtask

    // one text of mostly well-formed characters, sometimes cut short
    task automatic send_text();
        logic [BYTE_W-1:0] text_buf [0:TEXT_MAX-1];
        logic [BYTE_W-1:0] b;
        int n_bytes;
        int chars;
        int kind;
        int n_cont;
        int last;
        n_bytes = 0;
        chars   = $urandom_range(12, 1);
        for (int c = 0; c < chars; c++)
        begin
            kind = $urandom_range(99, 0);
            b    = BYTE_W'($urandom);
            if (kind < 40)
            begin
                b[7]   = 1'b0;
                n_cont = 0;
            end
            else if (kind < 60)
            begin
                b[7:5] = LEAD2_TAG;
                n_cont = 1;
            end
            else if (kind < 75)
            begin
                b[7:4] = LEAD3_TAG;
                n_cont = 2;
            end
            else if (kind < 85)
            begin
                b[7:3] = LEAD4_TAG;
                n_cont = 3;
            end
            else
            begin
                n_cont = 0;
            end
            text_buf[n_bytes] = b;
            n_bytes++;
            for (int k = 0; k < n_cont; k++)
            begin
                b = BYTE_W'($urandom);
                if ($urandom_range(19, 0) != 0)
                    b[7:6] = CONT_TAG;
                text_buf[n_bytes] = b;
                n_bytes++;
            end
        end
        last = n_bytes - 1;
        if (last > 0 && $urandom_range(5, 0) == 0)
            last = $urandom_range(last - 1, 0);
        for (int i = 0; i <= last; i++)
            send_byte(text_buf[i], i == last);
    endtask

    // output side: random back-pressure plus one long hold, requested once HOLD_AT bytes are sent
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
                out_ready <= 1'b1;
            end
            else
            begin
                gap = pick_gap();
                if (gap == 0)
                    out_ready <= 1'b1;
                else
                begin
                    out_ready <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
            end
        end
    end

    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, waiting);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        text_byte  = '0;
        final_byte = 1'b0;
        sent       = 0;
        calm       = 1'b1;
        hold_req   = 1'b0;
        hold_done  = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i][7:0], directed_bytes[i][8]);

        while (sent < TOTAL_ITEMS)
        begin
            calm = (sent < CALM_ITEMS);
            send_text();
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (waiting != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("sent %0d bytes; checked %0d code points, %0d of them truncation replacements",
                 sent, checked, replacements);
        $display("long output hold %s, %0d field mismatches",
                 hold_done ? "done" : "not reached", mismatches);
        if (mismatches == 0 && waiting == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
